// ===== src/mted_pkg.sv =====
// Shared types and constants for the Manchester edge timing decoder.
`timescale 1ns / 1ps

package mted_pkg;

  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int SLOT_WIDTH    = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_GLITCH_THRESHOLD = 3'd0,
    REG_SHORT_MIN        = 3'd1,
    REG_SHORT_MAX        = 3'd2,
    REG_LONG_MIN         = 3'd3,
    REG_LONG_MAX         = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_WIDTH-1:0] GLITCH_THRESHOLD_RST = 16'd32;
  localparam logic [CFG_WIDTH-1:0] SHORT_MIN_RST        = 16'd64;
  localparam logic [CFG_WIDTH-1:0] SHORT_MAX_RST        = 16'd192;
  localparam logic [CFG_WIDTH-1:0] LONG_MIN_RST         = 16'd192;
  localparam logic [CFG_WIDTH-1:0] LONG_MAX_RST         = 16'd320;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] glitch_threshold;
    logic [CFG_WIDTH-1:0] short_min;
    logic [CFG_WIDTH-1:0] short_max;
    logic [CFG_WIDTH-1:0] long_min;
    logic [CFG_WIDTH-1:0] long_max;
  } mted_cfg_t;

  typedef struct packed {
    logic                  decoded_bit;
    logic [SLOT_WIDTH-1:0] slot;
  } mted_res_t;

endpackage

// ===== src/mted_if.sv =====
// Channel interfaces: edge input, decoded bit output and register write port.
`timescale 1ns / 1ps

interface mted_in_if #(
  parameter int TIME_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] edge_time;
  logic                  pin_level;

  modport source (output valid, output edge_time, output pin_level, input ready);
  modport sink   (input valid, input edge_time, input pin_level, output ready);
endinterface

interface mted_out_if;
  import mted_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  decoded_bit;
  logic [SLOT_WIDTH-1:0] slot;

  modport source (output valid, output decoded_bit, output slot, input ready);
  modport sink   (input valid, input decoded_bit, input slot, output ready);
endinterface

interface mted_cfg_if;
  import mted_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [CFG_WIDTH-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/manchester_edge_timing_decoder.sv =====
// Top level of the Manchester edge timing decoder.
//
// in_ch carries one transfer per line edge: the timer capture value and the
// pin level after the edge. out_ch carries one transfer per decoded data bit
// together with the ring slot it was assigned. cfg_ch writes the five timing
// window registers by index (glitch threshold, short min/max, long min/max);
// it is always ready and is meant to be written while no edge is in flight.
//
// An edge lands in the input register and is classified and decoded from
// there; its bit (if any) is loaded into the output register that drives
// out_ch. One edge per cycle is sustained while out_ch does not stall with a
// bit pending; the lock state update is a loop closed on the decode stage.
// When out_ch stalls with a bit pending, decoding pauses, the input register
// holds its edge, and in_ch.ready drops once that register is full. Reset
// clears lock state, the slot counter and both stage valids, and loads the
// timing registers with their default values.
`timescale 1ns / 1ps

module manchester_edge_timing_decoder
  import mted_pkg::*;
#(
  parameter int RING_DEPTH = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mted_in_if.sink    in_ch,
  mted_out_if.source out_ch,
  mted_cfg_if.sink   cfg_ch
);

  mted_cfg_t cfg;
  mted_res_t res;
  logic      res_valid;
  logic      out_free;

  mted_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mted_core #(
    .RING_DEPTH (RING_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  mted_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/mted_cfg_regs.sv =====
// Timing window registers, written through the configuration port.
`timescale 1ns / 1ps

module mted_cfg_regs
  import mted_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mted_cfg_if.sink   cfg_ch,
  output mted_cfg_t  cfg
);

  mted_cfg_t cfg_r;
  mted_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GLITCH_THRESHOLD: cfg_nxt.glitch_threshold = cfg_ch.data;
        REG_SHORT_MIN:        cfg_nxt.short_min        = cfg_ch.data;
        REG_SHORT_MAX:        cfg_nxt.short_max        = cfg_ch.data;
        REG_LONG_MIN:         cfg_nxt.long_min         = cfg_ch.data;
        REG_LONG_MAX:         cfg_nxt.long_max         = cfg_ch.data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glitch_threshold <= GLITCH_THRESHOLD_RST;
      cfg_r.short_min        <= SHORT_MIN_RST;
      cfg_r.short_max        <= SHORT_MAX_RST;
      cfg_r.long_min         <= LONG_MIN_RST;
      cfg_r.long_max         <= LONG_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/mted_core.sv =====
// Edge input register, gap classification and lock/bit state.
`timescale 1ns / 1ps

module mted_core
  import mted_pkg::*;
#(
  parameter int RING_DEPTH = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mted_in_if.sink    in_ch,
  input  mted_cfg_t  cfg,
  input  logic       out_free,
  output logic       res_valid,
  output mted_res_t  res
);

  localparam int CMP_W  = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  // input register
  logic                  s1_valid_r;
  logic [TIME_WIDTH-1:0] s1_time_r;
  logic                  s1_pin_r;

  // decoder state
  logic                  started_r,  started_nxt;
  logic                  locked_r,   locked_nxt;
  logic                  await_r,    await_nxt;
  logic [TIME_WIDTH-1:0] prev_r,     prev_nxt;
  logic                  held_r,     held_nxt;
  logic [IDX_W-1:0]      slot_r,     slot_nxt;

  logic                  advance;
  logic [CMP_W-1:0]      gap;
  logic                  is_long;
  logic                  is_short;
  logic                  in_window;
  logic                  emit;
  logic                  bit_val;

  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || advance;

  assign gap       = CMP_W'(s1_time_r - prev_r);
  assign is_long   = (CMP_W'(cfg.long_min) < gap) && (gap < CMP_W'(cfg.long_max));
  assign is_short  = (CMP_W'(cfg.short_min) < gap) && (gap < CMP_W'(cfg.short_max));
  assign in_window = !((gap < CMP_W'(cfg.short_min)) || (gap > CMP_W'(cfg.long_max)));

  always_comb begin
    started_nxt = started_r;
    locked_nxt  = locked_r;
    await_nxt   = await_r;
    prev_nxt    = prev_r;
    held_nxt    = held_r;
    slot_nxt    = slot_r;
    emit        = 1'b0;
    bit_val     = held_r;
    if (advance) begin
      if (!started_r) begin
        started_nxt = 1'b1;
        prev_nxt    = s1_time_r;
      end else if (gap >= CMP_W'(cfg.glitch_threshold)) begin
        prev_nxt = s1_time_r;
        if (in_window) begin
          if (!locked_r) begin
            if (is_long) begin
              locked_nxt = 1'b1;
              held_nxt   = s1_pin_r;
            end
          end else if (await_r) begin
            await_nxt = 1'b0;
            // long gap after a lone short one is dropped
            if (!is_long) begin
              emit = 1'b1;
            end
          end else if (is_short) begin
            await_nxt = 1'b1;
          end else if (is_long) begin
            emit    = 1'b1;
            bit_val = ~held_r;
          end else begin
            locked_nxt  = 1'b0;
            started_nxt = 1'b0;
          end
        end
      end
      if (emit) begin
        held_nxt = bit_val;
        slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
      end
    end
  end

  assign res_valid       = emit;
  assign res.decoded_bit = bit_val;
  assign res.slot        = SLOT_WIDTH'({{SLOT_WIDTH{1'b0}}, slot_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_time_r <= in_ch.edge_time;
      s1_pin_r  <= in_ch.pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      locked_r  <= 1'b0;
      await_r   <= 1'b0;
      prev_r    <= '0;
      held_r    <= 1'b0;
      slot_r    <= '0;
    end else begin
      started_r <= started_nxt;
      locked_r  <= locked_nxt;
      await_r   <= await_nxt;
      prev_r    <= prev_nxt;
      held_r    <= held_nxt;
      slot_r    <= slot_nxt;
    end
  end

endmodule

// ===== src/mted_out_reg.sv =====
// Result register driving the decoded bit channel.
`timescale 1ns / 1ps

module mted_out_reg
  import mted_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  input  mted_res_t  res,
  output logic       out_free,
  mted_out_if.source out_ch
);

  logic      valid_r;
  mted_res_t data_r;

  assign out_free           = !valid_r || out_ch.ready;
  assign out_ch.valid       = valid_r;
  assign out_ch.decoded_bit = data_r.decoded_bit;
  assign out_ch.slot        = data_r.slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      data_r <= res;
    end
  end

endmodule

// ===== test/mted_checker.sv =====
// Decode predictor and result checker for the Manchester edge timing decoder.
`timescale 1ns / 1ps

module mted_checker
  import mted_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mted_in_if          in_mon,
  mted_out_if         out_mon,
  mted_cfg_if         cfg_mon,
  output int unsigned pending,
  output int unsigned failures
);

  mted_cfg_t   timing;
  logic        started;
  logic        locked;
  logic        awaiting_second;
  logic        held_bit;
  logic [15:0] last_edge;
  int unsigned ring_pos;
  int unsigned fail_cnt;
  mted_res_t   expected_bits[$];

  // Advances the line state by one edge and queues the bit it yields, if any.
  function automatic void decode_edge(input logic [15:0] now, input logic pin);
    logic [15:0] gap;
    logic        is_long;
    logic        is_short;
    logic        bit_out;
    mted_res_t   res;
    gap = now - last_edge;
    if (!started) begin
      started   = 1'b1;
      last_edge = now;
      return;
    end
    if (gap < timing.glitch_threshold) return;
    last_edge = now;
    if (gap < timing.short_min || gap > timing.long_max) return;
    is_long  = (gap > timing.long_min) && (gap < timing.long_max);
    is_short = (gap > timing.short_min) && (gap < timing.short_max);
    if (!locked) begin
      if (is_long) begin
        locked   = 1'b1;
        held_bit = pin;
      end
      return;
    end
    if (awaiting_second) begin
      awaiting_second = 1'b0;
      if (is_long) return;
      bit_out = held_bit;
    end else if (is_short) begin
      awaiting_second = 1'b1;
      return;
    end else if (is_long) begin
      bit_out = ~held_bit;
    end else begin
      // in window but neither short nor long: sync lost
      locked  = 1'b0;
      started = 1'b0;
      return;
    end
    held_bit        = bit_out;
    res.decoded_bit = bit_out;
    res.slot        = SLOT_WIDTH'(ring_pos % RING_DEPTH);
    ring_pos        = (ring_pos + 1) % RING_DEPTH;
    expected_bits.push_back(res);
  endfunction

  always @(posedge clk) begin
    mted_res_t want;
    if (!rst_n) begin
      timing.glitch_threshold = GLITCH_THRESHOLD_RST;
      timing.short_min        = SHORT_MIN_RST;
      timing.short_max        = SHORT_MAX_RST;
      timing.long_min         = LONG_MIN_RST;
      timing.long_max         = LONG_MAX_RST;
      started                 = 1'b0;
      locked                  = 1'b0;
      awaiting_second         = 1'b0;
      held_bit                = 1'b0;
      last_edge               = '0;
      ring_pos                = 0;
      fail_cnt                = 0;
      expected_bits.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_GLITCH_THRESHOLD: timing.glitch_threshold = cfg_mon.data;
          REG_SHORT_MIN:        timing.short_min        = cfg_mon.data;
          REG_SHORT_MAX:        timing.short_max        = cfg_mon.data;
          REG_LONG_MIN:         timing.long_min         = cfg_mon.data;
          REG_LONG_MAX:         timing.long_max         = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        decode_edge(in_mon.edge_time, in_mon.pin_level);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bits.size() == 0) begin
          $error("unexpected transfer: decoded_bit %0d slot %0d",
                 out_mon.decoded_bit, out_mon.slot);
          fail_cnt++;
        end else begin
          want = expected_bits.pop_front();
          if (out_mon.decoded_bit !== want.decoded_bit) begin
            $error("decoded_bit: expected %0d, actual %0d",
                   want.decoded_bit, out_mon.decoded_bit);
            fail_cnt++;
          end
          if (out_mon.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_mon.slot);
            fail_cnt++;
          end
        end
      end
    end
    pending  <= expected_bits.size();
    failures <= fail_cnt;
  end

endmodule

// ===== test/tb_top.sv =====
// Stimulus, handshake pacing and verdict for the Manchester edge timing decoder.
`timescale 1ns / 1ps

module tb_top;
  import mted_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LONG_HOLD    = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned pending_bits;
  int unsigned fail_count;
  int unsigned hold_requests = 0;

  // stimulus-side view of the line
  mted_cfg_t   cur_cfg;
  logic [15:0] t_now;
  logic        pin_now;
  int unsigned burst_left;
  int unsigned edges_sent;

  int unsigned directed_gaps[22] = '{31, 250, 250, 100, 100, 100, 250, 250, 32, 64, 300,
                                     320, 321, 193, 192, 1000, 200, 65535, 319, 65,
                                     191, 320};

  mted_in_if  in_if ();
  mted_out_if out_if ();
  mted_cfg_if cfg_if ();

  manchester_edge_timing_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  mted_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .cfg_mon  (cfg_if),
    .pending  (pending_bits),
    .failures (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("[manchester_edge_timing_decoder] ERROR");
    $finish;
  end

  // Receiver: stall rate is redrawn at the end of each random-length pattern; long hold-offs on request.
  initial begin
    int unsigned stall_pct;
    int unsigned pattern_left;
    int unsigned hold_left;
    int unsigned holds_done;
    stall_pct    = 0;
    pattern_left = 0;
    hold_left    = 0;
    holds_done   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(256, 32);
          case ($urandom_range(4, 0))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end else begin
          pattern_left--;
        end
        out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Sends one edge 'gap' ticks after the last recorded edge, in bursts with idle gaps.
  task automatic send_gap(input int unsigned gap);
    logic [15:0] stamp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      if ($urandom_range(3, 0) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
    burst_left--;
    stamp = t_now + 16'(gap);
    // glitch edges leave the recorded time alone
    if (gap >= cur_cfg.glitch_threshold) t_now = stamp;
    if ($urandom_range(9, 0) == 0) pin_now = 1'($urandom_range(1, 0));
    else pin_now = ~pin_now;
    in_if.valid     <= 1'b1;
    in_if.edge_time <= stamp;
    in_if.pin_level <= pin_now;
    do @(posedge clk); while (!in_if.ready);
    edges_sent++;
  endtask

  function automatic int unsigned in_window(input int unsigned lo_excl,
                                            input int unsigned hi_excl);
    if (hi_excl > lo_excl + 1) return $urandom_range(hi_excl - 1, lo_excl + 1);
    return $urandom_range(65535, 0);
  endfunction

  // Mostly well-formed Manchester symbols, some noise.
  task automatic send_symbol();
    int unsigned r;
    int unsigned b;
    r = $urandom_range(99, 0);
    if (r < 45) begin
      send_gap(in_window(cur_cfg.long_min, cur_cfg.long_max));
    end else if (r < 85) begin
      send_gap(in_window(cur_cfg.short_min, cur_cfg.short_max));
      send_gap(in_window(cur_cfg.short_min, cur_cfg.short_max));
    end else if (r < 90) begin
      if (cur_cfg.glitch_threshold != 0)
        send_gap($urandom_range(cur_cfg.glitch_threshold - 1, 0));
      else
        send_gap($urandom_range(65535, 0));
    end else if (r < 95) begin
      case ($urandom_range(4, 0))
        0:       b = cur_cfg.glitch_threshold;
        1:       b = cur_cfg.short_min;
        2:       b = cur_cfg.short_max;
        3:       b = cur_cfg.long_min;
        default: b = cur_cfg.long_max;
      endcase
      send_gap((b + 16'hFFFF + $urandom_range(2, 0)) & 16'hFFFF);
    end else begin
      send_gap($urandom_range(65535, 0));
    end
  endtask

  // Waits until every expected bit has come out and the pipeline has drained.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_bits != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic run_phase(input mted_cfg_t c, input int unsigned n);
    int unsigned target;
    int unsigned k;
    wait_idle();
    write_reg(REG_GLITCH_THRESHOLD, c.glitch_threshold);
    write_reg(REG_SHORT_MIN, c.short_min);
    write_reg(REG_SHORT_MAX, c.short_max);
    write_reg(REG_LONG_MIN, c.long_min);
    write_reg(REG_LONG_MAX, c.long_max);
    // an index past the register list must be ignored
    write_reg(CFG_IDX_WIDTH'($urandom_range(2 ** CFG_IDX_WIDTH - 1, REG_LONG_MAX + 1)),
              CFG_WIDTH'($urandom_range(65535, 0)));
    cfg_if.valid <= 1'b0;
    cur_cfg = c;
    target  = edges_sent + n;
    // output held off while full-bit edges keep coming, so the input backs up
    hold_requests <= hold_requests + 1;
    burst_left = 30;
    for (k = 0; k < 30; k++) send_gap(in_window(cur_cfg.long_min, cur_cfg.long_max));
    while (edges_sent < target) send_symbol();
  endtask

  initial begin
    mted_cfg_t   c;
    int unsigned k;
    in_if.valid     = 1'b0;
    in_if.edge_time = '0;
    in_if.pin_level = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_GLITCH_THRESHOLD;
    cfg_if.data     = '0;
    rst_n           = 1'b0;
    cur_cfg = '{GLITCH_THRESHOLD_RST, SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST,
                LONG_MAX_RST};
    t_now      = 16'd65500;
    pin_now    = 1'b0;
    burst_left = 0;
    edges_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start near the wrap, glitch, lock, toggles, repeats,
    // long after one short, every window edge, gap equal to long_max
    send_gap(0);
    foreach (directed_gaps[k]) send_gap(directed_gaps[k]);

    run_phase(cur_cfg, 250);
    run_phase('{16'd8, 16'd20, 16'd60, 16'd60, 16'd100}, 250);
    // extremes and inverted windows
    run_phase('{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF}, 60);
    run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 60);
    run_phase('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 60);
    run_phase('{16'd16, 16'd200, 16'd100, 16'd400, 16'd300}, 60);
    for (k = 0; k < 3; k++) begin
      c.glitch_threshold = 16'($urandom_range(40, 0));
      c.short_min        = c.glitch_threshold + 16'($urandom_range(40, 0));
      c.short_max        = c.short_min + 16'($urandom_range(200, 2));
      c.long_min         = c.short_max - 16'($urandom_range(3, 0));
      c.long_max         = c.long_min + 16'($urandom_range(300, 2));
      run_phase(c, 250);
    end
    c = '{16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
          16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
          16'($urandom_range(65535, 0))};
    run_phase(c, 60);

    wait_idle();
    if (fail_count == 0)
      $display("[manchester_edge_timing_decoder] OK");
    else
      $display("[manchester_edge_timing_decoder] ERROR");
    $finish;
  end

endmodule
